@@ rtl/projected_polygon_screen_test_macros.svh @@
// Assertion macros for the polygon screen test block
`ifndef PROJECTED_POLYGON_SCREEN_TEST_MACROS_SVH
`define PROJECTED_POLYGON_SCREEN_TEST_MACROS_SVH

// same-cycle implication
`define PPS_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pps: implication check failed");

// next-cycle implication
`define PPS_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pps: next-cycle check failed");

`endif

@@ rtl/pps_pkg.sv @@
// Shared types and constants of the polygon screen test block
package pps_pkg;

   localparam int REG_COUNT       = 6;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 64;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ROW_X_FIRST  = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ROW_X_SECOND = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ROW_Y_FIRST  = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ROW_Y_SECOND = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ROW_W_FIRST  = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ROW_W_SECOND = 3'd5;

   localparam logic [CSR_DATA_WIDTH-1:0] CFG_RESET [REG_COUNT] = '{
      64'h0001_0000_0000_0000, 64'h0, 64'h0000_0000_0001_0000,
      64'h0, 64'h0, 64'h0000_0000_0001_0000};

   typedef struct packed {
      logic signed [31:0] vertex_x;
      logic signed [31:0] vertex_y;
      logic signed [31:0] vertex_z;
      logic               last_vertex;
   } req_type;

   typedef struct packed {
      logic visible;
      logic divide_fault;
   } rsp_type;

endpackage

@@ rtl/pps_mul.sv @@
// Shared signed multiplier with registered product
module pps_mul #(
   parameter int MW = 33
) (
   input  logic                  clock,
   input  logic signed [MW-1:0]  mul_a,
   input  logic signed [MW-1:0]  mul_b,
   output logic signed [2*MW-1:0] product_ff
);
   logic signed [2*MW-1:0] product_in;

   assign product_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end
endmodule

@@ rtl/pps_div.sv @@
// Restoring serial divider: saturated fixed-point quotient num / den
module pps_div #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [63:0]            num,
   input  logic signed [63:0]            den,
   output logic                          busy,
   output logic                          done,
   output logic signed [COORD_WIDTH-1:0] quot
);
   localparam int CW   = COORD_WIDTH;
   localparam int DDW  = 64 + FRAC_BITS;
   localparam int CNTW = $clog2(CW + 1);
   localparam logic [CW-1:0] CAP_M1 = {1'b0, {(CW-1){1'b1}}};
   localparam logic [CW-1:0] MIN_V  = {1'b1, {(CW-1){1'b0}}};

   logic            busy_ff, busy_in, done_ff, done_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [63:0]     rem_ff, rem_in, b_ff, b_in;
   logic [CW-1:0]   low_ff, low_in, q_ff, q_in, quot_ff, quot_in;
   logic            neg_ff, neg_in, sat_ff, sat_in, zero_ff, zero_in;
   logic [63:0]     a_mag, b_mag;
   logic [DDW-1:0]  dvd, hi_ext;
   logic [64:0]     rem2;
   logic            ge, big;

   always_comb begin
      a_mag  = num[63] ? (64'd0 - num) : num;
      b_mag  = den[63] ? (64'd0 - den) : den;
      dvd    = {a_mag, {FRAC_BITS{1'b0}}};
      hi_ext = dvd >> CW;
      rem2   = {rem_ff, low_ff[CW-1]};
      ge     = rem2 >= {1'b0, b_ff};
      big    = sat_ff | q_ff[CW-1];

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      b_in    = b_ff;
      low_in  = low_ff;
      q_in    = q_ff;
      neg_in  = neg_ff;
      sat_in  = sat_ff;
      zero_in = zero_ff;
      quot_in = quot_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNTW'(CW);
         rem_in  = hi_ext[63:0];
         b_in    = b_mag;
         low_in  = dvd[CW-1:0];
         q_in    = '0;
         neg_in  = num[63] != den[63];
         zero_in = a_mag == 64'd0;
         sat_in  = hi_ext >= DDW'(b_mag);
      end else if (busy_ff) begin
         if (cnt_ff != '0) begin
            rem_in = ge ? 64'(rem2 - {1'b0, b_ff}) : rem2[63:0];
            q_in   = {q_ff[CW-2:0], ge};
            low_in = low_ff << 1;
            cnt_in = cnt_ff - 1'b1;
         end else begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (zero_ff) begin
               quot_in = '0;
            end else if (neg_ff) begin
               quot_in = big ? MIN_V : (CW'(0) - q_ff);
            end else begin
               quot_in = big ? CAP_M1 : q_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      b_ff    <= b_in;
      low_ff  <= low_in;
      q_ff    <= q_in;
      neg_ff  <= neg_in;
      sat_ff  <= sat_in;
      zero_ff <= zero_in;
      quot_ff <= quot_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = quot_ff;
endmodule

@@ rtl/projected_polygon_screen_test.sv @@
// Top level: vertex projection, divide by w and edge-versus-box test sequencer
// Per vertex: nine multiplies, two serial divides by w, then an edge test per edge
//   (box check, then the multiplier on each of the 4 corners when the box does not reject it).
// One vertex at a time: req_ready stays low until the vertex is done. The last vertex
//   adds the closing edge and a response that waits until the output is free.
// Synchronous active-high reset: matrix registers take their defaults, polygon state clears.
`include "projected_polygon_screen_test_macros.svh"
module projected_polygon_screen_test #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  pps_pkg::req_type                       req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output pps_pkg::rsp_type                       rsp_data,
   input  logic                                   csr_write_en,
   input  logic [pps_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [pps_pkg::CSR_DATA_WIDTH-1:0]     csr_data
);
   import pps_pkg::*;

   localparam int CW  = COORD_WIDTH;
   localparam int F   = FRAC_BITS;
   localparam int EW  = ((CW > F + 1) ? CW : F + 2) + 1;
   localparam int EDW = EW + 1;
   localparam int MW  = (EDW > 33) ? EDW : 33;
   localparam int PW  = 2 * MW;
   localparam logic signed [EW-1:0] ONE = EW'(1 << F);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_PMUL = 4'd1;
   localparam logic [3:0] S_PACC = 4'd2;
   localparam logic [3:0] S_DXS  = 4'd3;
   localparam logic [3:0] S_DXW  = 4'd4;
   localparam logic [3:0] S_DYS  = 4'd5;
   localparam logic [3:0] S_DYW  = 4'd6;
   localparam logic [3:0] S_UPD  = 4'd7;
   localparam logic [3:0] S_EBOX = 4'd8;
   localparam logic [3:0] S_EP   = 4'd9;
   localparam logic [3:0] S_EQ   = 4'd10;
   localparam logic [3:0] S_EC   = 4'd11;
   localparam logic [3:0] S_OUT  = 4'd12;

   logic [CSR_DATA_WIDTH-1:0] cfg_ff [REG_COUNT];

   logic [3:0]              state_ff, state_in;
   logic signed [CW-1:0]    vx_ff, vx_in, vy_ff, vy_in, vz_ff, vz_in;
   logic                    last_ff, last_in;
   logic [1:0]              row_ff, row_in, col_ff, col_in, corner_ff, corner_in;
   logic signed [63:0]      acc_ff, acc_in, hx_ff, hx_in, hy_ff, hy_in, hw_ff, hw_in;
   logic signed [CW-1:0]    sx_ff, sx_in, sy_ff, sy_in;
   logic signed [CW-1:0]    first_x_ff, first_x_in, first_y_ff, first_y_in;
   logic signed [CW-1:0]    prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic                    have_first_ff, have_first_in, hit_seen_ff, hit_seen_in;
   logic                    fault_seen_ff, fault_seen_in, closing_ff, closing_in;
   logic                    all_pos_ff, all_pos_in, all_neg_ff, all_neg_in;
   logic signed [EW-1:0]    ax_ff, ax_in, ay_ff, ay_in, bx_ff, bx_in, by_ff, by_in;
   logic signed [PW-1:0]    p_ff, p_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   logic [CSR_DATA_WIDTH-1:0] first_pair, second_pair;
   logic signed [31:0]      coef;
   logic signed [CW-1:0]    coord;
   logic signed [63:0]      term, row_sum;
   logic signed [MW-1:0]    mul_a, mul_b;
   logic signed [PW-1:0]    product_ff;
   logic signed [EDW-1:0]   dx, dy, cy_ay, cx_ax;
   logic signed [EW-1:0]    cx, cy, max_x, min_x, max_y, min_y;
   logic                    box_reject, edge_done, edge_hit, pos_n, neg_n;
   logic                    div_start, div_busy, div_done;
   logic signed [63:0]      div_num;
   logic signed [CW-1:0]    div_quot;

   pps_mul #(.MW(MW)) u_mul (
      .clock      (clock),
      .mul_a      (mul_a),
      .mul_b      (mul_b),
      .product_ff (product_ff)
   );

   pps_div #(.COORD_WIDTH(CW), .FRAC_BITS(F)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (hw_ff),
      .busy  (div_busy),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            cfg_ff[i] <= CFG_RESET[i];
         end
      end else if (csr_write_en && csr_index <= REG_ROW_W_SECOND) begin
         cfg_ff[csr_index] <= csr_data;
      end
   end

   always_comb begin
      first_pair  = cfg_ff[{row_ff, 1'b0}];
      second_pair = cfg_ff[{row_ff, 1'b1}];
      case (col_ff)
         2'd0:    begin coef = first_pair[63:32];  coord = vx_ff; end
         2'd1:    begin coef = first_pair[31:0];   coord = vy_ff; end
         default: begin coef = second_pair[63:32]; coord = vz_ff; end
      endcase
      term    = 64'(product_ff >>> F);
      row_sum = acc_ff + term + 64'($signed(second_pair[31:0]));

      cx    = corner_ff[0] ? ONE : -ONE;
      cy    = corner_ff[1] ? ONE : -ONE;
      dx    = EDW'(bx_ff) - EDW'(ax_ff);
      dy    = EDW'(by_ff) - EDW'(ay_ff);
      cy_ay = EDW'(cy) - EDW'(ay_ff);
      cx_ax = EDW'(cx) - EDW'(ax_ff);
      max_x = (ax_ff > bx_ff) ? ax_ff : bx_ff;
      min_x = (ax_ff < bx_ff) ? ax_ff : bx_ff;
      max_y = (ay_ff > by_ff) ? ay_ff : by_ff;
      min_y = (ay_ff < by_ff) ? ay_ff : by_ff;
      box_reject = (max_x < -ONE) || (min_x > ONE) || (max_y < -ONE) || (min_y > ONE);
      pos_n = all_pos_ff & (p_ff > product_ff);
      neg_n = all_neg_ff & (p_ff < product_ff);

      case (state_ff)
         S_PMUL:  begin mul_a = MW'(coef); mul_b = MW'(coord); end
         S_EP:    begin mul_a = MW'(dx);   mul_b = MW'(cy_ay); end
         default: begin mul_a = MW'(dy);   mul_b = MW'(cx_ax); end
      endcase

      div_start = (state_ff == S_DXS) || (state_ff == S_DYS);
      div_num   = (state_ff == S_DYS) ? hy_ff : hx_ff;
   end

   always_comb begin
      state_in      = state_ff;
      vx_in         = vx_ff;
      vy_in         = vy_ff;
      vz_in         = vz_ff;
      last_in       = last_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      corner_in     = corner_ff;
      acc_in        = acc_ff;
      hx_in         = hx_ff;
      hy_in         = hy_ff;
      hw_in         = hw_ff;
      sx_in         = sx_ff;
      sy_in         = sy_ff;
      first_x_in    = first_x_ff;
      first_y_in    = first_y_ff;
      prev_x_in     = prev_x_ff;
      prev_y_in     = prev_y_ff;
      have_first_in = have_first_ff;
      hit_seen_in   = hit_seen_ff;
      fault_seen_in = fault_seen_ff;
      closing_in    = closing_ff;
      all_pos_in    = all_pos_ff;
      all_neg_in    = all_neg_ff;
      ax_in         = ax_ff;
      ay_in         = ay_ff;
      bx_in         = bx_ff;
      by_in         = by_ff;
      p_in          = p_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      edge_done     = 1'b0;
      edge_hit      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               vx_in    = CW'(req_data.vertex_x);
               vy_in    = CW'(req_data.vertex_y);
               vz_in    = CW'(req_data.vertex_z);
               last_in  = req_data.last_vertex;
               row_in   = 2'd0;
               col_in   = 2'd0;
               acc_in   = '0;
               state_in = S_PMUL;
            end
         end
         S_PMUL: state_in = S_PACC;
         S_PACC: begin
            state_in = S_PMUL;
            if (col_ff == 2'd2) begin
               acc_in = '0;
               col_in = 2'd0;
               row_in = row_ff + 2'd1;
               case (row_ff)
                  2'd0:    hx_in = row_sum;
                  2'd1:    hy_in = row_sum;
                  default: begin
                     hw_in    = row_sum;
                     state_in = S_DXS;
                  end
               endcase
            end else begin
               acc_in = acc_ff + term;
               col_in = col_ff + 2'd1;
            end
         end
         S_DXS: begin
            fault_seen_in = fault_seen_ff | (hw_ff == 64'sd0);
            state_in      = S_DXW;
         end
         S_DXW: begin
            if (div_done) begin
               sx_in    = div_quot;
               state_in = S_DYS;
            end
         end
         S_DYS: state_in = S_DYW;
         S_DYW: begin
            if (div_done) begin
               sy_in    = div_quot;
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            prev_x_in = sx_ff;
            prev_y_in = sy_ff;
            if (!have_first_ff) begin
               first_x_in    = sx_ff;
               first_y_in    = sy_ff;
               have_first_in = 1'b1;
               if (last_ff) begin
                  ax_in      = EW'(sx_ff);
                  ay_in      = EW'(sy_ff);
                  bx_in      = EW'(sx_ff);
                  by_in      = EW'(sy_ff);
                  closing_in = 1'b1;
                  state_in   = S_EBOX;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               ax_in      = EW'(prev_x_ff);
               ay_in      = EW'(prev_y_ff);
               bx_in      = EW'(sx_ff);
               by_in      = EW'(sy_ff);
               closing_in = 1'b0;
               state_in   = S_EBOX;
            end
         end
         S_EBOX: begin
            corner_in  = 2'd0;
            all_pos_in = 1'b1;
            all_neg_in = 1'b1;
            if (box_reject) begin
               edge_done = 1'b1;
            end else begin
               state_in = S_EP;
            end
         end
         S_EP: state_in = S_EQ;
         S_EQ: begin
            p_in     = product_ff;
            state_in = S_EC;
         end
         S_EC: begin
            all_pos_in = pos_n;
            all_neg_in = neg_n;
            corner_in  = corner_ff + 2'd1;
            if (corner_ff == 2'd3) begin
               edge_done = 1'b1;
               edge_hit  = !(pos_n || neg_n);
            end else begin
               state_in = S_EP;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.visible       = hit_seen_ff;
               rsp_data_in.divide_fault  = fault_seen_ff;
               hit_seen_in               = 1'b0;
               fault_seen_in             = 1'b0;
               have_first_in             = 1'b0;
               state_in                  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (edge_done) begin
         hit_seen_in = hit_seen_ff | edge_hit;
         if (closing_ff) begin
            state_in = S_OUT;
         end else if (last_ff) begin
            ax_in      = EW'(sx_ff);
            ay_in      = EW'(sy_ff);
            bx_in      = EW'(first_x_ff);
            by_in      = EW'(first_y_ff);
            closing_in = 1'b1;
            state_in   = S_EBOX;
         end else begin
            state_in = S_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         first_x_ff    <= '0;
         first_y_ff    <= '0;
         prev_x_ff     <= '0;
         prev_y_ff     <= '0;
         have_first_ff <= 1'b0;
         hit_seen_ff   <= 1'b0;
         fault_seen_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         first_x_ff    <= first_x_in;
         first_y_ff    <= first_y_in;
         prev_x_ff     <= prev_x_in;
         prev_y_ff     <= prev_y_in;
         have_first_ff <= have_first_in;
         hit_seen_ff   <= hit_seen_in;
         fault_seen_ff <= fault_seen_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      vx_ff       <= vx_in;
      vy_ff       <= vy_in;
      vz_ff       <= vz_in;
      last_ff     <= last_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      corner_ff   <= corner_in;
      acc_ff      <= acc_in;
      hx_ff       <= hx_in;
      hy_ff       <= hy_in;
      hw_ff       <= hw_in;
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      closing_ff  <= closing_in;
      all_pos_ff  <= all_pos_in;
      all_neg_ff  <= all_neg_in;
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      bx_ff       <= bx_in;
      by_ff       <= by_in;
      p_ff        <= p_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `PPS_ASSERT_NXT(a_busy_after_request, req_valid && req_ready, !req_ready)
   `PPS_ASSERT_IMP(a_rsp_from_out, $rose(rsp_valid_ff), $past(state_ff) == S_OUT)
   `PPS_ASSERT_IMP(a_div_free_on_start, div_start, !div_busy)
endmodule
